[rtl/xcl_pkg.sv]
// Shared constants, types and helper function for the XOR checksum line receiver.
`timescale 1ns / 1ps

package xcl_pkg;

  localparam int unsigned LINE_LIMIT = 128;
  localparam int unsigned LEN_W      = 8;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_LIMIT);

  typedef enum logic [2:0] {
    FAIL_NONE      = 3'd0,
    FAIL_NO_COLON  = 3'd1,
    FAIL_FIELD_LEN = 3'd2,
    FAIL_NON_HEX   = 3'd3,
    FAIL_MISMATCH  = 3'd4
  } fail_reason_e;

  typedef struct packed {
    logic             frame_valid;
    fail_reason_e     fail_reason;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       computed_checksum;
    logic [7:0]       received_checksum;
  } verdict_t;

  // Bit 4 set marks a character that is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      v = {1'b0, 4'(c - 8'h57)};
    end
    return v;
  endfunction

endpackage

[rtl/xcl_line_tracker.sv]
// Line state registers and the verdict logic for one line.
`timescale 1ns / 1ps

module xcl_line_tracker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              upd_i,
  input  logic [7:0]        byte_i,
  output xcl_pkg::verdict_t verdict_o
);
  import xcl_pkg::*;

  logic [LEN_W-1:0] line_len_q, line_len_d;
  logic [7:0]       run_xor_q, run_xor_d;
  logic [7:0]       colon_xor_q, colon_xor_d;
  logic             colon_seen_q, colon_seen_d;
  logic [LEN_W-1:0] colon_pos_q, colon_pos_d;
  logic [1:0]       cac_q, cac_d;
  logic [7:0]       dig1_q, dig1_d;
  logic [7:0]       dig2_q, dig2_d;
  logic             zero_seen_q, zero_seen_d;

  logic             is_cr, is_lf;
  logic [4:0]       hi_val, lo_val;
  logic [7:0]       recv;

  assign is_cr = (byte_i == CH_CR);
  assign is_lf = (byte_i == CH_LF);

  always_comb begin
    line_len_d   = line_len_q;
    run_xor_d    = run_xor_q;
    colon_xor_d  = colon_xor_q;
    colon_seen_d = colon_seen_q;
    colon_pos_d  = colon_pos_q;
    cac_d        = cac_q;
    dig1_d       = dig1_q;
    dig2_d       = dig2_q;
    zero_seen_d  = zero_seen_q;
    if (upd_i && !is_cr) begin
      if (is_lf) begin
        // verdict is taken from the current state; the line starts afresh
        line_len_d   = '0;
        run_xor_d    = '0;
        colon_xor_d  = '0;
        colon_seen_d = 1'b0;
        colon_pos_d  = '0;
        cac_d        = '0;
        dig1_d       = '0;
        dig2_d       = '0;
        zero_seen_d  = 1'b0;
      end else if (line_len_q < LEN_LIMIT) begin
        if (!zero_seen_q) begin
          if (byte_i == CH_NUL) begin
            zero_seen_d = 1'b1;
          end else if (byte_i == CH_COLON) begin
            colon_xor_d  = run_xor_q;
            colon_seen_d = 1'b1;
            colon_pos_d  = line_len_q;
            cac_d        = '0;
            dig1_d       = '0;
            dig2_d       = '0;
            run_xor_d    = run_xor_q ^ byte_i;
          end else begin
            run_xor_d = run_xor_q ^ byte_i;
            if (colon_seen_q) begin
              if (cac_q == 2'd0) dig1_d = byte_i;
              if (cac_q == 2'd1) dig2_d = byte_i;
              if (cac_q != 2'd3) cac_d = cac_q + 2'd1;
            end
          end
        end
        line_len_d = line_len_q + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q   <= '0;
      run_xor_q    <= '0;
      colon_xor_q  <= '0;
      colon_seen_q <= 1'b0;
      colon_pos_q  <= '0;
      cac_q        <= '0;
      dig1_q       <= '0;
      dig2_q       <= '0;
      zero_seen_q  <= 1'b0;
    end else begin
      line_len_q   <= line_len_d;
      run_xor_q    <= run_xor_d;
      colon_xor_q  <= colon_xor_d;
      colon_seen_q <= colon_seen_d;
      colon_pos_q  <= colon_pos_d;
      cac_q        <= cac_d;
      dig1_q       <= dig1_d;
      dig2_q       <= dig2_d;
      zero_seen_q  <= zero_seen_d;
    end
  end

  assign hi_val = hex_value(dig1_q);
  assign lo_val = hex_value(dig2_q);
  assign recv   = {hi_val[3:0], lo_val[3:0]};

  always_comb begin
    verdict_o.frame_valid       = 1'b0;
    verdict_o.fail_reason       = FAIL_NO_COLON;
    verdict_o.payload_length    = line_len_q;
    verdict_o.computed_checksum = run_xor_q;
    verdict_o.received_checksum = '0;
    if (colon_seen_q) begin
      verdict_o.payload_length    = colon_pos_q;
      verdict_o.computed_checksum = colon_xor_q;
      if (cac_q != 2'd2) begin
        verdict_o.fail_reason = FAIL_FIELD_LEN;
      end else if (hi_val[4] || lo_val[4]) begin
        verdict_o.fail_reason = FAIL_NON_HEX;
      end else begin
        verdict_o.received_checksum = recv;
        if (recv == colon_xor_q) begin
          verdict_o.fail_reason = FAIL_NONE;
          verdict_o.frame_valid = 1'b1;
        end else begin
          verdict_o.fail_reason = FAIL_MISMATCH;
        end
      end
    end
  end

endmodule

[rtl/xor_checksum_line_receiver_top.sv]
// Top level of the XOR checksum line receiver: input register, line tracker, result register.
`timescale 1ns / 1ps

// Usage
//   Input channel: one received byte per transfer on rx_byte_i (in_valid_i / in_stall_o).
//   CR is ignored; LF closes the line and gives exactly one result; other bytes
//   build up the line and give no result.
//   Output channel: one verdict per line (out_valid_o / out_stall_i) with
//   frame_valid, fail_reason, payload_length, computed and received checksum.
//   Throughput: one byte per cycle while the input is not stalled, set by the single
//   register-to-register update of the line state.
//   Path: the LF of a line sits in the input register, then the verdict is loaded
//   into the result register, which offers it on the output channel.
//   Stalls: the result register holds a verdict while out_stall_i is high;
//   ordinary bytes keep flowing, and only an LF waiting behind a held verdict
//   stalls the input.
//   Reset (rst_ni low, asynchronous) empties both registers and clears the line
//   state; no result is pending afterwards.
module xor_checksum_line_receiver_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       frame_valid_o,
  output logic [2:0] fail_reason_o,
  output logic [7:0] payload_length_o,
  output logic [7:0] computed_checksum_o,
  output logic [7:0] received_checksum_o
);
  import xcl_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       held_lf;
  logic       advance;
  logic       load_out;
  logic       out_vld_q;
  verdict_t   verdict;
  verdict_t   res_q;

  assign held_lf  = (in_byte_q == CH_LF);
  // the held byte moves on unless it is an LF and the result slot stays busy
  assign advance  = in_vld_q && !(held_lf && out_vld_q && out_stall_i);
  assign load_out = advance && held_lf;
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  xcl_line_tracker u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (advance),
    .byte_i    (in_byte_q),
    .verdict_o (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_q <= verdict;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign frame_valid_o       = res_q.frame_valid;
  assign fail_reason_o       = res_q.fail_reason;
  assign payload_length_o    = res_q.payload_length;
  assign computed_checksum_o = res_q.computed_checksum;
  assign received_checksum_o = res_q.received_checksum;

endmodule
